// ----- src/lbp_3x3_stream_top_defines.svh -----
// Assertion macros for the 3x3 LBP stream block.
`ifndef LBP_3X3_STREAM_TOP_DEFINES_SVH
`define LBP_3X3_STREAM_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbp assertion failed");

// Next-cycle implication, checked out of reset.
`define LBP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbp assertion failed");

`endif

// ----- src/lbp_pkg.sv -----
// Shared types and constants for the 3x3 LBP stream block.
package lbp_pkg;

  localparam int PIX_W    = 8;
  localparam int CFG_W    = 12;
  localparam int FWIDTH_W = 11;
  localparam int FHEIGHT_W = 12;

  localparam logic [FWIDTH_W-1:0]  FWIDTH_RST  = 11'd640;
  localparam logic [FHEIGHT_W-1:0] FHEIGHT_RST = 12'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } lbp_reg_t;

  // Per-pixel result flags decided from the pixel position.
  typedef struct packed {
    logic emit;
    logic last;
  } lbp_flags_t;

endpackage

// ----- src/lbp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module lbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/lbp_pos.sv -----
// Frame geometry registers and raster position counters.
module lbp_pos
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_addr,
  input  logic [CFG_W-1:0]             cfg_wdata,
  input  logic                         adv,
  output logic [$clog2(MAX_WIDTH)-1:0] col,
  output lbp_flags_t                   flags
);

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int MWB = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (MWB > FWIDTH_W) ? MWB : FWIDTH_W;

  logic [FWIDTH_W-1:0]  width_r, width_nxt;
  logic [FHEIGHT_W-1:0] height_r, height_nxt;
  logic [XW-1:0]        col_r, col_nxt;
  logic [FHEIGHT_W-1:0] row_r, row_nxt;

  logic [EW-1:0]        w_raw, eff_w, x_ext, x_inc;
  logic [FHEIGHT_W-1:0] eff_h;
  logic [FHEIGHT_W:0]   y_inc;
  logic                 col_wrap, row_wrap;

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_we) begin
      unique case (lbp_reg_t'(cfg_addr))
        REG_FRAME_WIDTH:  width_nxt  = cfg_wdata[FWIDTH_W-1:0];
        REG_FRAME_HEIGHT: height_nxt = cfg_wdata[FHEIGHT_W-1:0];
      endcase
    end
  end

  // Zero size counts as one, width saturates at the line store depth.
  always_comb begin
    w_raw = EW'(width_r);
    if (w_raw == '0) begin
      eff_w = EW'(1);
    end else if (w_raw > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = w_raw;
    end
    eff_h = (height_r == '0) ? FHEIGHT_W'(1) : height_r;
  end

  always_comb begin
    x_ext    = EW'(col_r);
    x_inc    = x_ext + EW'(1);
    y_inc    = {1'b0, row_r} + (FHEIGHT_W+1)'(1);
    col_wrap = (x_inc >= eff_w);
    row_wrap = (y_inc >= {1'b0, eff_h});

    flags.emit = (x_ext >= EW'(2)) && (row_r >= FHEIGHT_W'(2)) &&
                 (x_ext < eff_w) && (row_r < eff_h);
    flags.last = (x_inc == eff_w) && (y_inc == {1'b0, eff_h});

    col_nxt = col_r;
    row_nxt = row_r;
    if (adv) begin
      if (col_wrap) begin
        col_nxt = '0;
        row_nxt = row_wrap ? '0 : y_inc[FHEIGHT_W-1:0];
      end else begin
        col_nxt = x_inc[XW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FWIDTH_RST;
      height_r <= FHEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  assign col = col_r;

endmodule

// ----- src/lbp_win.sv -----
// 3x3 window columns, LBP code compare and output register.
module lbp_win
  import lbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  lbp_flags_t       flags,
  input  logic [PIX_W-1:0] top,
  input  logic [PIX_W-1:0] mid,
  input  logic [PIX_W-1:0] bot,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [PIX_W-1:0] out_code,
  output logic             out_last
);

  // Index 0..2: top/mid/bottom of column x-2; 3..5: column x-1.
  logic [PIX_W-1:0] win_r [6];
  logic [PIX_W-1:0] win_nxt [6];
  logic [PIX_W-1:0] code, ctr;
  logic             valid_r, valid_nxt;
  logic [PIX_W-1:0] code_r;
  logic             last_r;

  always_comb begin
    ctr     = win_r[4];
    code[7] = (win_r[0] >= ctr);
    code[6] = (win_r[3] >= ctr);
    code[5] = (top      >= ctr);
    code[4] = (mid      >= ctr);
    code[3] = (bot      >= ctr);
    code[2] = (win_r[5] >= ctr);
    code[1] = (win_r[2] >= ctr);
    code[0] = (win_r[1] >= ctr);
  end

  always_comb begin
    win_nxt = win_r;
    if (fire) begin
      win_nxt[0] = win_r[3];
      win_nxt[1] = win_r[4];
      win_nxt[2] = win_r[5];
      win_nxt[3] = top;
      win_nxt[4] = mid;
      win_nxt[5] = bot;
    end
    if (fire && flags.emit) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      valid_r <= valid_nxt;
      win_r   <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && flags.emit) begin
      code_r <= code;
      last_r <= flags.last;
    end
  end

  assign out_valid = valid_r;
  assign out_code  = code_r;
  assign out_last  = last_r;

endmodule

// ----- src/lbp_3x3_stream_top.sv -----
// Top level of the streaming 3x3 local binary pattern block.
//
// Input: one 8-bit grey pixel per beat on in_*, raster order, frame size
// from frame_width / frame_height registers (cfg_addr 0 / 1), to be written
// on the cfg port only while the block is idle, which it does not enforce.
// Output: one beat on out_* per interior pixel, carrying the 8-bit LBP code
// of the pixel one row up and one column left of the pixel that caused it;
// out_tlast marks the last interior code of the frame. Border pixels and
// frames narrower or shorter than three give no beats.
// Throughput: one pixel per clock while out_tready is high. The two previous
// rows live in one 16-bit wide line RAM, read at the incoming column and
// written back when the pixel leaves the read stage; a pixel at the same column
// as the one ahead of it (width one) takes its row data from a forwarding
// register instead of the RAM. An accepted pixel and its RAM read data are
// registered in the read stage; its code goes into the output register when
// the read stage passes it on, and is then shown on out_*.
// Reset clears the position counters, the window and the output valid and
// loads width 640, height 480; line RAM contents are not cleared and no
// clearing pass is run.
// When out_tready is low the result waits in the output register; one more
// pixel is still taken into the read stage, after which in_tready drops.
`include "lbp_3x3_stream_top_defines.svh"

module lbp_3x3_stream_top
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [7:0] pixel
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [7:0] lbp_code
  output logic             out_tlast,  // frame_last
  input  logic             cfg_we,
  input  logic [0:0]       cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int RW = 2 * PIX_W;

  logic          acc, fire, same_col;
  logic [XW-1:0] col;
  lbp_flags_t    flags;

  logic             p1_valid_r, p1_valid_nxt;
  logic [XW-1:0]    p1_x_r;
  logic [PIX_W-1:0] p1_pix_r;
  lbp_flags_t       p1_flags_r;
  logic             fwd_r;
  logic [RW-1:0]    fwd_data_r;

  logic [RW-1:0]    ram_rdata, rows, wb_data;
  logic [PIX_W-1:0] top, mid;

  lbp_pos #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pos (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .adv       (acc),
    .col       (col),
    .flags     (flags)
  );

  // Upper byte: row two up; lower byte: row one up.
  lbp_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_WIDTH)
  ) u_rows (
    .clk   (clk),
    .we    (fire),
    .waddr (p1_x_r),
    .wdata (wb_data),
    .re    (acc),
    .raddr (col),
    .rdata (ram_rdata)
  );

  assign fire      = p1_valid_r && (!out_tvalid || out_tready);
  assign in_tready = !p1_valid_r || fire;
  assign acc       = in_tvalid && in_tready;
  assign same_col  = fire && (col == p1_x_r);

  assign rows    = fwd_r ? fwd_data_r : ram_rdata;
  assign top     = rows[RW-1:PIX_W];
  assign mid     = rows[PIX_W-1:0];
  assign wb_data = {mid, p1_pix_r};

  always_comb begin
    if (acc) begin
      p1_valid_nxt = 1'b1;
    end else if (fire) begin
      p1_valid_nxt = 1'b0;
    end else begin
      p1_valid_nxt = p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= p1_valid_nxt;
    end
  end

  // Read stage payload, plus a bypass of the write landing at the read column.
  always_ff @(posedge clk) begin
    if (acc) begin
      p1_x_r     <= col;
      p1_pix_r   <= in_tdata;
      p1_flags_r <= flags;
      fwd_r      <= same_col;
      fwd_data_r <= wb_data;
    end
  end

  lbp_win u_win (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .flags     (p1_flags_r),
    .top       (top),
    .mid       (mid),
    .bot       (p1_pix_r),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_code  (out_tdata),
    .out_last  (out_tlast)
  );

  `LBP_ASSERT_NXT(a_emit_shows, fire && p1_flags_r.emit, out_tvalid)
  `LBP_ASSERT_NXT(a_stage_holds, p1_valid_r && !fire, p1_valid_r && $stable(p1_x_r))
  `LBP_ASSERT_IMP(a_stall_cause, !in_tready, p1_valid_r && out_tvalid && !out_tready)

endmodule
